FILE: design/i2d_pkg.sv
// Shared types and constants for the integer to decimal ASCII sender.
// Used by i2d_dabble and integer_to_decimal_ascii_sender; depends on nothing.

package i2d_pkg;

	localparam int VALUE_BITS_DEF = 32;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [3:0] DIGIT_MAX   = 4'd9;

	// double-dabble correction: a digit of five or more gets three added before the shift
	localparam logic [3:0] DABBLE_LIMIT = 4'd5;
	localparam logic [3:0] DABBLE_ADD   = 4'd3;

	// Decimal digits needed for a bits-wide unsigned number (log10(2) ~ 0.30103).
	function automatic int num_digits(input int bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT,
		ST_DELIM
	} state_t;

	typedef struct packed {
		logic load;        // take a new magnitude, clear the digits
		logic step;        // one correct-and-shift iteration
		logic next_digit;  // move the next digit into the top position
	} dabble_ctrl_t;

endpackage

FILE: design/i2d_dabble.sv
// Iterative binary to BCD converter (shift and add three), one bit per step.
// Depends on i2d_pkg for the control struct and the digit count.

module i2d_dabble #(
	parameter int VALUE_BITS = i2d_pkg::VALUE_BITS_DEF
) (
	input  logic                    clk,
	input  i2d_pkg::dabble_ctrl_t   ctrl,
	input  logic [VALUE_BITS-1:0]   load_value,
	output logic [3:0]              top_digit
);

	localparam int NDIG  = i2d_pkg::num_digits(VALUE_BITS);
	localparam int BCD_W = 4 * NDIG;

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;

	always_comb begin
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[4*d +: 4] >= i2d_pkg::DABBLE_LIMIT) begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + i2d_pkg::DABBLE_ADD;
			end else begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= load_value;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			{bcd_q, bin_q} <= {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
		end else if (ctrl.next_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

endmodule

FILE: design/integer_to_decimal_ascii_sender.sv
// Top level of the integer to decimal ASCII sender: sequencer and output register.
// Depends on i2d_pkg and i2d_dabble.

// One input beat carries an integer, a signed/unsigned flag and a delimiter byte;
// the block sends back its decimal text one byte per beat: '-' for a negative
// signed value, the digits most significant first without leading zeros ('0'
// for zero), then the delimiter flagged with tlast. The most negative signed
// value is sent with its full magnitude. One shift-and-add-three BCD unit does
// the conversion, one value bit per cycle, then the digits are shifted out one
// per cycle while the output register can take them. The input is not ready
// while an item is in work; the next item is taken while the delimiter still
// waits in the output register.

module integer_to_decimal_ascii_sender #(
	parameter int VALUE_BITS = i2d_pkg::VALUE_BITS_DEF,
	localparam int IN_W = ((VALUE_BITS + 8 + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [IN_W-1:0] s_axis_tdata,   // value [VALUE_BITS-1:0], delimiter, zero fill
	input  logic            s_axis_tuser,   // mode: 0 signed, 1 unsigned
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // text_byte
	output logic            m_axis_tlast
);

	localparam int NDIG = i2d_pkg::num_digits(VALUE_BITS);
	localparam int BC_W = $clog2(VALUE_BITS + 1);
	localparam int DC_W = $clog2(NDIG + 1);

	i2d_pkg::state_t       state_q, state_d;
	i2d_pkg::dabble_ctrl_t ctrl;

	logic [BC_W-1:0]       bit_cnt_q;
	logic [DC_W-1:0]       dig_cnt_q;
	logic                  started_q;
	logic                  neg_q;
	logic [7:0]            delim_q;
	logic                  out_valid_q;
	logic [7:0]            out_data_q;
	logic                  out_last_q;

	logic                  in_neg;
	logic [VALUE_BITS-1:0] in_value;
	logic [VALUE_BITS-1:0] magnitude;
	logic [3:0]            top_digit;
	logic                  slot_free;
	logic                  out_load;
	logic [7:0]            out_byte;
	logic                  out_last_d;
	logic                  dig_dec;
	logic                  set_started;

	assign in_value  = s_axis_tdata[VALUE_BITS-1:0];
	assign in_neg    = !s_axis_tuser && in_value[VALUE_BITS-1];
	assign magnitude = in_neg ? (~in_value + 1'b1) : in_value;
	assign slot_free = !out_valid_q || m_axis_tready;

	i2d_dabble #(
		.VALUE_BITS(VALUE_BITS)
	) u_dabble (
		.clk        (clk),
		.ctrl       (ctrl),
		.load_value (magnitude),
		.top_digit  (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2d_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctrl          = '0;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		out_byte      = delim_q;
		out_last_d    = 1'b0;
		dig_dec       = 1'b0;
		set_started   = 1'b0;
		unique case (state_q)
			i2d_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					ctrl.load = 1'b1;
					state_d   = i2d_pkg::ST_CONV;
				end
			end
			i2d_pkg::ST_CONV: begin
				ctrl.step = 1'b1;
				if (bit_cnt_q == BC_W'(1)) begin
					state_d = neg_q ? i2d_pkg::ST_SIGN : i2d_pkg::ST_EMIT;
				end
			end
			i2d_pkg::ST_SIGN: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_byte = i2d_pkg::ASCII_MINUS;
					state_d  = i2d_pkg::ST_EMIT;
				end
			end
			i2d_pkg::ST_EMIT: begin
				// drop leading zeros, but always keep the units digit
				if (!started_q && top_digit == 4'd0 && dig_cnt_q != DC_W'(1)) begin
					ctrl.next_digit = 1'b1;
					dig_dec         = 1'b1;
				end else if (slot_free) begin
					out_load        = 1'b1;
					out_byte        = i2d_pkg::ASCII_ZERO | {4'd0, top_digit};
					ctrl.next_digit = 1'b1;
					dig_dec         = 1'b1;
					set_started     = 1'b1;
					if (dig_cnt_q == DC_W'(1)) begin
						state_d = i2d_pkg::ST_DELIM;
					end
				end
			end
			i2d_pkg::ST_DELIM: begin
				if (slot_free) begin
					out_load   = 1'b1;
					out_last_d = 1'b1;
					state_d    = i2d_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = i2d_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q   <= '0;
			dig_cnt_q   <= '0;
			started_q   <= 1'b0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				bit_cnt_q <= BC_W'(VALUE_BITS);
				dig_cnt_q <= DC_W'(NDIG);
				started_q <= 1'b0;
				neg_q     <= in_neg;
			end else begin
				if (ctrl.step) begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
				end
				if (dig_dec) begin
					dig_cnt_q <= dig_cnt_q - 1'b1;
				end
				if (set_started) begin
					started_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			delim_q <= s_axis_tdata[VALUE_BITS +: 8];
		end
		if (out_load) begin
			out_data_q <= out_byte;
			out_last_q <= out_last_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=>
			(state_q == i2d_pkg::ST_CONV && bit_cnt_q == BC_W'(VALUE_BITS)))
		else $error("accepted beat did not start a full conversion");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2d_pkg::ST_EMIT) |-> (top_digit <= i2d_pkg::DIGIT_MAX))
		else $error("BCD digit out of range");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2d_pkg::ST_EMIT) |-> (dig_cnt_q != '0))
		else $error("digit count ran out while emitting");

	a_first_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2d_pkg::ST_EMIT && out_load && !started_q && dig_cnt_q != DC_W'(1))
			|-> (top_digit != 4'd0))
		else $error("leading zero sent");

	a_text_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |->
			(m_axis_tdata == i2d_pkg::ASCII_MINUS ||
			 (m_axis_tdata >= i2d_pkg::ASCII_ZERO &&
			  m_axis_tdata <= (i2d_pkg::ASCII_ZERO | {4'd0, i2d_pkg::DIGIT_MAX}))))
		else $error("non-delimiter beat is not a digit or minus");

endmodule
